>>> hw/rtl/fesf_pkg.sv
`timescale 1ns / 1ps

package fesf_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_BASIS_KIND = 1'b0;
  localparam logic REG_DIMENSIONS = 1'b1;

  // Basis family codes.
  localparam logic [1:0] KIND_LINEAR    = 2'd0;
  localparam logic [1:0] KIND_QUADRATIC = 2'd1;
  localparam logic [1:0] KIND_HERMITE   = 2'd2;

  localparam logic [1:0] MAX_AXES = 2'd3;

  // Coordinates are unsigned Q1.15; polynomials are evaluated exactly over 2^45.
  localparam int COORD_W    = 16;
  localparam int COORD_FRAC = 15;
  localparam int EXACT_FRAC = 45;

  // Horner intermediate widths, set by the coordinate width and coefficient range.
  localparam int T1W = 21;
  localparam int T2W = 38;
  localparam int T3W = 56;

  localparam int OUT_W   = 20;
  localparam int OUT_MAX = 524287;
  localparam int OUT_MIN = -524288;

  typedef struct packed {
    logic signed [3:0] a0;
    logic signed [3:0] a1;
    logic signed [3:0] a2;
    logic signed [3:0] a3;
  } coef_t;

  // Control flags that travel with each transaction through the pipeline.
  typedef struct packed {
    logic bad;
    logic kill;
    logic use_y;
    logic use_z;
  } meta_t;

  function automatic coef_t mk_coef(int c0, int c1, int c2, int c3);
    coef_t r;
    r.a0 = 4'(c0);
    r.a1 = 4'(c1);
    r.a2 = 4'(c2);
    r.a3 = 4'(c3);
    return r;
  endfunction

  // Coefficients of a0 + a1 x + a2 x^2 + a3 x^3 for one 1-D function or its derivative.
  function automatic coef_t poly_coef(logic [1:0] kind, logic [1:0] fn, logic der);
    coef_t r;
    case ({kind, fn, der})
      {KIND_LINEAR, 2'd0, 1'b0}:    r = mk_coef(1, -1, 0, 0);
      {KIND_LINEAR, 2'd0, 1'b1}:    r = mk_coef(-1, 0, 0, 0);
      {KIND_LINEAR, 2'd1, 1'b0}:    r = mk_coef(0, 1, 0, 0);
      {KIND_LINEAR, 2'd1, 1'b1}:    r = mk_coef(1, 0, 0, 0);
      {KIND_QUADRATIC, 2'd0, 1'b0}: r = mk_coef(1, -3, 2, 0);
      {KIND_QUADRATIC, 2'd0, 1'b1}: r = mk_coef(-3, 4, 0, 0);
      {KIND_QUADRATIC, 2'd1, 1'b0}: r = mk_coef(0, 4, -4, 0);
      {KIND_QUADRATIC, 2'd1, 1'b1}: r = mk_coef(4, -8, 0, 0);
      {KIND_QUADRATIC, 2'd2, 1'b0}: r = mk_coef(0, -1, 2, 0);
      {KIND_QUADRATIC, 2'd2, 1'b1}: r = mk_coef(-1, 4, 0, 0);
      {KIND_HERMITE, 2'd0, 1'b0}:   r = mk_coef(1, 0, -3, 2);
      {KIND_HERMITE, 2'd0, 1'b1}:   r = mk_coef(0, -6, 6, 0);
      {KIND_HERMITE, 2'd1, 1'b0}:   r = mk_coef(0, 1, -2, 1);
      {KIND_HERMITE, 2'd1, 1'b1}:   r = mk_coef(1, -4, 3, 0);
      {KIND_HERMITE, 2'd2, 1'b0}:   r = mk_coef(0, 0, 3, -2);
      {KIND_HERMITE, 2'd2, 1'b1}:   r = mk_coef(0, 6, -6, 0);
      {KIND_HERMITE, 2'd3, 1'b0}:   r = mk_coef(0, 0, -1, 1);
      {KIND_HERMITE, 2'd3, 1'b1}:   r = mk_coef(0, -2, 3, 0);
      default:                      r = mk_coef(0, 0, 0, 0);
    endcase
    return r;
  endfunction

  function automatic logic [2:0] basis_count(logic [1:0] kind);
    logic [2:0] n;
    unique case (kind)
      KIND_LINEAR:    n = 3'd2;
      KIND_QUADRATIC: n = 3'd3;
      default:        n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

>>> hw/rtl/fesf_poly.sv
`timescale 1ns / 1ps

// Four-stage evaluation of one 1-D cubic by Horner's rule, exact, then rounded.
module fesf_poly #(
  parameter int FRAC_BITS = 15
) (
  input  logic                        clk,
  input  logic [3:0]                  adv,
  input  logic [1:0]                  kind,
  input  logic [1:0]                  func,
  input  logic                        der,
  input  logic [15:0]                 coord,
  output logic signed [FRAC_BITS+4:0] value
);

  localparam int VW = FRAC_BITS + 5;
  localparam int SH = fesf_pkg::EXACT_FRAC - FRAC_BITS;
  localparam logic signed [fesf_pkg::T3W-1:0] HALF = fesf_pkg::T3W'(1) <<< (SH - 1);

  fesf_pkg::coef_t coef;
  logic signed [fesf_pkg::T1W-1:0] t1_nxt;
  logic signed [fesf_pkg::T1W-1:0] t1_r;
  logic signed [16:0]              c1_r, c2_r;
  logic signed [3:0]               a1_1_r, a0_1_r, a0_2_r;
  logic signed [fesf_pkg::T2W-1:0] t2_nxt;
  logic signed [fesf_pkg::T2W-1:0] t2_r;
  logic signed [fesf_pkg::T3W-1:0] t3_nxt;
  logic signed [fesf_pkg::T3W-1:0] t3_r;
  logic signed [fesf_pkg::T3W-1:0] rnd;
  logic signed [VW-1:0]            value_r;
  logic signed [16:0]              c_s;

  always_comb begin
    coef   = fesf_pkg::poly_coef(kind, func, der);
    c_s    = $signed({1'b0, coord});
    t1_nxt = fesf_pkg::T1W'(coef.a3) * fesf_pkg::T1W'(c_s)
           + (fesf_pkg::T1W'(coef.a2) <<< fesf_pkg::COORD_FRAC);
    t2_nxt = fesf_pkg::T2W'(t1_r) * fesf_pkg::T2W'(c1_r)
           + (fesf_pkg::T2W'(a1_1_r) <<< (2 * fesf_pkg::COORD_FRAC));
    t3_nxt = fesf_pkg::T3W'(t2_r) * fesf_pkg::T3W'(c2_r)
           + (fesf_pkg::T3W'(a0_2_r) <<< fesf_pkg::EXACT_FRAC);
    rnd    = t3_r + HALF;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t1_r   <= t1_nxt;
      c1_r   <= c_s;
      a1_1_r <= coef.a1;
      a0_1_r <= coef.a0;
    end
    if (adv[1]) begin
      t2_r   <= t2_nxt;
      c2_r   <= c1_r;
      a0_2_r <= a0_1_r;
    end
    if (adv[2]) begin
      t3_r <= t3_nxt;
    end
    if (adv[3]) begin
      value_r <= VW'(rnd >>> SH);
    end
  end

  assign value = value_r;

endmodule

>>> hw/rtl/fe_shape_function_eval.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while out_stall is low; eight register stages, each with a valid bit.
// The deepest stage is the 38 x 17 bit Horner multiply inside each axis unit.
// Reset (rst_n low, synchronous) empties the pipeline and loads basis_kind = linear
// and dimensions = 2.

module fe_shape_function_eval #(
  parameter int FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func_x,
  input  logic [1:0]         in_func_y,
  input  logic [1:0]         in_func_z,
  input  logic [15:0]        in_coord_x,
  input  logic [15:0]        in_coord_y,
  input  logic [15:0]        in_coord_z,
  input  logic [1:0]         in_deriv_axis,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] out_shape_value,
  output logic               out_bad_index,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Pipeline layout:
  //   stages 1-4: per-axis Horner evaluation and rounding (three fesf_poly units)
  //   stage 5:    first product x * y (y replaced by 1.0 when that axis is unused)
  //   stage 6:    rounding of the first product back to FRAC_BITS
  //   stage 7:    second product with z (again 1.0 when unused)
  //   stage 8:    rounding, saturation, zeroing of killed transactions; output register
  // Multiplying by exactly 1.0 and rounding is the identity, so an unused axis
  // needs no separate bypass path.
  localparam int NST = 8;
  localparam int VW  = FRAC_BITS + 5;
  localparam int AW  = FRAC_BITS + 9;
  localparam int P1W = 2 * VW;
  localparam int QW  = AW + VW;
  localparam int OW  = fesf_pkg::OUT_W;

  localparam logic signed [VW-1:0]  ONE_Q = VW'(1) <<< FRAC_BITS;
  localparam logic signed [P1W-1:0] HALF1 = P1W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [QW-1:0]  HALF2 = QW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [QW-1:0]  SAT_HI = QW'(fesf_pkg::OUT_MAX);
  localparam logic signed [QW-1:0]  SAT_LO = QW'(fesf_pkg::OUT_MIN);

  // Configuration registers. Writes are word aligned: paddr[2] picks the register.
  logic [1:0] basis_kind_r;
  logic [1:0] dimensions_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_kind_r <= fesf_pkg::KIND_LINEAR;
      dimensions_r <= 2'd2;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        fesf_pkg::REG_BASIS_KIND: basis_kind_r <= pwdata[1:0];
        fesf_pkg::REG_DIMENSIONS: dimensions_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      fesf_pkg::REG_BASIS_KIND: prdata[1:0] = basis_kind_r;
      fesf_pkg::REG_DIMENSIONS: prdata[1:0] = dimensions_r;
      default: ;
    endcase
  end

  assign pready = 1'b1;

  // Front-end decode: effective basis kind and axis count, index check, and the
  // kill flag for a bad index or a derivative along an axis outside the product.
  logic [1:0]      kind_eff;
  logic [1:0]      dims_eff;
  logic [2:0]      count;
  fesf_pkg::meta_t meta_in;

  always_comb begin
    kind_eff = (basis_kind_r > fesf_pkg::KIND_HERMITE) ? fesf_pkg::KIND_HERMITE
                                                       : basis_kind_r;
    dims_eff = dimensions_r;
    if (dims_eff == 2'd0) begin
      dims_eff = 2'd1;
    end
    if (dims_eff > fesf_pkg::MAX_AXES) begin
      dims_eff = fesf_pkg::MAX_AXES;
    end
    count         = fesf_pkg::basis_count(kind_eff);
    meta_in.use_y = (dims_eff >= 2'd2);
    meta_in.use_z = (dims_eff >= 2'd3);
    meta_in.bad   = ({1'b0, in_func_x} >= count)
                 || (meta_in.use_y && ({1'b0, in_func_y} >= count))
                 || (meta_in.use_z && ({1'b0, in_func_z} >= count));
    meta_in.kill  = meta_in.bad || (in_deriv_axis > dims_eff);
  end

  // Valid bits and flow control. A stage takes new data when it is empty or when
  // the stage after it is taking its contents, so a stall ripples back only as
  // far as it has to and no bubble blocks the pipeline.
  logic [NST:1]    vld_r;
  logic [NST+1:1]  rdy;
  fesf_pkg::meta_t meta_r [1:NST];

  always_comb begin
    rdy[NST+1] = !out_stall;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  // The input side is held off while reset is asserted, since nothing offered
  // then could be kept.
  assign in_stall  = !rdy[1] || !rst_n;
  assign out_valid = vld_r[NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      meta_r[1] <= meta_in;
    end
    for (int k = 2; k <= NST; k++) begin
      if (rdy[k]) begin
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  // Per-axis polynomial units, stages 1 to 4.
  logic signed [VW-1:0] v_x, v_y, v_z;

  fesf_poly #(.FRAC_BITS(FRAC_BITS)) u_poly_x (
    .clk   (clk),
    .adv   (rdy[4:1]),
    .kind  (kind_eff),
    .func  (in_func_x),
    .der   (in_deriv_axis == 2'd1),
    .coord (in_coord_x),
    .value (v_x)
  );

  fesf_poly #(.FRAC_BITS(FRAC_BITS)) u_poly_y (
    .clk   (clk),
    .adv   (rdy[4:1]),
    .kind  (kind_eff),
    .func  (in_func_y),
    .der   (in_deriv_axis == 2'd2),
    .coord (in_coord_y),
    .value (v_y)
  );

  fesf_poly #(.FRAC_BITS(FRAC_BITS)) u_poly_z (
    .clk   (clk),
    .adv   (rdy[4:1]),
    .kind  (kind_eff),
    .func  (in_func_z),
    .der   (in_deriv_axis == 2'd3),
    .coord (in_coord_z),
    .value (v_z)
  );

  // Product stages.
  logic signed [VW-1:0]  vy_sel, vz_sel;
  logic signed [P1W-1:0] p1_nxt, p1_r;
  logic signed [VW-1:0]  vz5_r, vz6_r;
  logic signed [P1W-1:0] rnd1;
  logic signed [AW-1:0]  acc1_r;
  logic signed [QW-1:0]  p2_nxt, p2_r;
  logic signed [QW-1:0]  rnd2, acc2;
  logic signed [OW-1:0]  shape_nxt;
  logic signed [OW-1:0]  out_shape_value_r;
  logic                  out_bad_index_r;

  always_comb begin
    vy_sel = meta_r[4].use_y ? v_y : ONE_Q;
    vz_sel = meta_r[4].use_z ? v_z : ONE_Q;
    p1_nxt = P1W'(v_x) * P1W'(vy_sel);
    rnd1   = p1_r + HALF1;
    p2_nxt = QW'(acc1_r) * QW'(vz6_r);
    rnd2   = p2_r + HALF2;
    acc2   = rnd2 >>> FRAC_BITS;
    if (meta_r[7].kill) begin
      shape_nxt = '0;
    end else if (acc2 > SAT_HI) begin
      shape_nxt = OW'(SAT_HI);
    end else if (acc2 < SAT_LO) begin
      shape_nxt = OW'(SAT_LO);
    end else begin
      shape_nxt = OW'(acc2);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      p1_r  <= p1_nxt;
      vz5_r <= vz_sel;
    end
    if (rdy[6]) begin
      acc1_r <= AW'(rnd1 >>> FRAC_BITS);
      vz6_r  <= vz5_r;
    end
    if (rdy[7]) begin
      p2_r <= p2_nxt;
    end
    if (rdy[8]) begin
      out_shape_value_r <= shape_nxt;
      out_bad_index_r   <= meta_r[7].bad;
    end
  end

  assign out_shape_value = out_shape_value_r;
  assign out_bad_index   = out_bad_index_r;

  // A result flagged for a bad index always carries a zero value.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> out_shape_value == '0)
    else $error("bad index result with nonzero value");

  // An accepted transaction occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[1])
    else $error("accepted transaction lost at pipeline entry");

  // A transaction leaving the polynomial units is taken by the product stage.
  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] && rdy[5] |=> vld_r[5])
    else $error("transaction lost between stages 4 and 5");

  // An empty pipeline with no incoming transaction cannot produce a result.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-1:1] == '0 && !out_valid |=> !out_valid)
    else $error("result appeared from an empty pipeline");

endmodule
